@@ rtl/pngccf_pkg.sv @@
// ----------------------------------------------------------------------------
// pngccf_pkg
// Shared types, constants and CRC-32 byte update for the PNG chunk framer.
// ----------------------------------------------------------------------------
package pngccf_pkg;

    localparam int LENGTH_BITS_DEF = 31;
    localparam int LEN_W           = 31;
    localparam int BYTE_W          = 8;
    localparam int WORD_W          = 32;
    localparam int QDEPTH          = 2;

    localparam logic [WORD_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;

    typedef enum logic {
        OP_BEGIN = 1'b0,
        OP_DATA  = 1'b1
    } op_t;

    // data holds the chunk type for OP_BEGIN and the byte (low bits) for OP_DATA.
    // last: zero-length chunk on OP_BEGIN, final data byte on OP_DATA.
    typedef struct packed {
        op_t                kind;
        logic               last;
        logic [WORD_W-1:0]  data;
        logic [LEN_W-1:0]   len;
    } q_entry_t;

    // reflected CRC-32, one byte per call
    function automatic logic [WORD_W-1:0] crc_fold(input logic [WORD_W-1:0] c,
                                                   input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] x;
        x = c ^ WORD_W'(b);
        for (int k = 0; k < BYTE_W; k++) begin
            x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic [BYTE_W-1:0] word_byte(input logic [WORD_W-1:0] w,
                                                    input logic [1:0] idx);
        return w[{idx, 3'b000} +: BYTE_W];
    endfunction

endpackage

@@ rtl/pngccf_front.sv @@
// ----------------------------------------------------------------------------
// pngccf_front
// Accepts input words, tracks the open chunk and its byte count, drops data
// outside a chunk and tags begin / data / last-byte operations for the back end.
// ----------------------------------------------------------------------------
module pngccf_front
    import pngccf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                q_full,
    input  logic                cmd,
    input  logic [WORD_W-1:0]   chunk_type,
    input  logic [LEN_W-1:0]    data_length,
    input  logic [BYTE_W-1:0]   data_byte,
    output logic                wr_valid,
    output q_entry_t            wr_entry
);

    logic                   open_reg;
    logic                   open_next;
    logic [LENGTH_BITS-1:0] rem_reg;
    logic [LENGTH_BITS-1:0] rem_next;
    logic [LENGTH_BITS-1:0] len_m;
    logic                   accept;

    assign len_m  = data_length[LENGTH_BITS-1:0];
    assign accept = push && !q_full;

    always_comb
    begin
        open_next      = open_reg;
        rem_next       = rem_reg;
        wr_valid       = 1'b0;
        wr_entry.kind  = OP_BEGIN;
        wr_entry.last  = 1'b0;
        wr_entry.data  = chunk_type;
        wr_entry.len   = LEN_W'(len_m);
        if (accept)
        begin
            if (op_t'(cmd) == OP_BEGIN)
            begin
                wr_valid      = 1'b1;
                wr_entry.last = (len_m == '0);
                open_next     = (len_m != '0);
                rem_next      = len_m;
            end
            else if (open_reg)
            begin
                wr_valid      = 1'b1;
                wr_entry.kind = OP_DATA;
                wr_entry.data = WORD_W'(data_byte);
                wr_entry.last = (rem_reg == LENGTH_BITS'(1));
                rem_next      = rem_reg - 1'b1;
                if (rem_reg == LENGTH_BITS'(1))
                begin
                    open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else
        begin
            open_reg <= open_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

@@ rtl/pngccf_queue.sv @@
// ----------------------------------------------------------------------------
// pngccf_queue
// Short operation queue between the front and the back end.
// ----------------------------------------------------------------------------
module pngccf_queue
    import pngccf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    input  q_entry_t  wr_entry,
    input  logic      rd_pop,
    output logic      full,
    output logic      rd_valid,
    output q_entry_t  rd_entry
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    q_entry_t         mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_valid, rd_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(QDEPTH)) && !(wr_valid && full) && !(rd_pop && !rd_valid))
        else $error("queue overflow or underflow");

endmodule

@@ rtl/pngccf_back.sv @@
// ----------------------------------------------------------------------------
// pngccf_back
// Sequencer that turns queued operations into output bytes: length, type,
// data and the inverted CRC, the CRC folded one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
module pngccf_back
    import pngccf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  q_entry_t            q_entry,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output logic [BYTE_W-1:0]   out_byte,
    output logic                chunk_end
);

    typedef enum logic [1:0] {
        ST_HEAD,
        ST_LEN,
        ST_TYPE,
        ST_CRC
    } state_t;

    state_t             st_reg;
    state_t             st_next;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    logic [WORD_W-1:0]  crc_reg;
    logic [WORD_W-1:0]  crc_next;
    logic [WORD_W-1:0]  type_reg;
    logic [WORD_W-1:0]  type_next;
    logic [WORD_W-1:0]  len_reg;
    logic [WORD_W-1:0]  len_next;
    logic               zero_reg;
    logic               zero_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [BYTE_W-1:0]  out_byte_next;
    logic               chunk_end_reg;
    logic               chunk_end_next;
    logic               adv;
    logic [WORD_W-1:0]  head_len;
    logic [BYTE_W-1:0]  head_byte;

    assign adv       = !out_valid_reg || pop;
    assign head_len  = WORD_W'(q_entry.len);
    assign head_byte = q_entry.data[BYTE_W-1:0];

    always_comb
    begin
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        crc_next       = crc_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !pop;
        out_byte_next  = out_byte_reg;
        chunk_end_next = chunk_end_reg;
        q_pop          = 1'b0;
        if (adv)
        begin
            unique case (st_reg)
                ST_HEAD:
                begin
                    if (q_valid)
                    begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        chunk_end_next = 1'b0;
                        if (q_entry.kind == OP_BEGIN)
                        begin
                            out_byte_next = word_byte(head_len, 2'd3);
                            type_next     = q_entry.data;
                            len_next      = head_len;
                            zero_next     = q_entry.last;
                            crc_next      = CRC_PRESET;
                            st_next       = ST_LEN;
                            cnt_next      = 2'd2;
                        end
                        else
                        begin
                            out_byte_next = head_byte;
                            crc_next      = crc_fold(crc_reg, head_byte);
                            if (q_entry.last)
                            begin
                                st_next  = ST_CRC;
                                cnt_next = 2'd3;
                            end
                        end
                    end
                end
                ST_LEN:
                begin
                    out_valid_next = 1'b1;
                    chunk_end_next = 1'b0;
                    out_byte_next  = word_byte(len_reg, cnt_reg);
                    cnt_next       = cnt_reg - 1'b1;
                    if (cnt_reg == 2'd0)
                    begin
                        st_next  = ST_TYPE;
                        cnt_next = 2'd3;
                    end
                end
                ST_TYPE:
                begin
                    out_valid_next = 1'b1;
                    chunk_end_next = 1'b0;
                    out_byte_next  = word_byte(type_reg, cnt_reg);
                    crc_next       = crc_fold(crc_reg, word_byte(type_reg, cnt_reg));
                    cnt_next       = cnt_reg - 1'b1;
                    if (cnt_reg == 2'd0)
                    begin
                        st_next  = zero_reg ? ST_CRC : ST_HEAD;
                        cnt_next = 2'd3;
                    end
                end
                ST_CRC:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = word_byte(~crc_reg, cnt_reg);
                    chunk_end_next = (cnt_reg == 2'd0);
                    cnt_next       = cnt_reg - 1'b1;
                    if (cnt_reg == 2'd0)
                    begin
                        st_next  = ST_HEAD;
                        crc_next = CRC_PRESET;
                    end
                end
                default:
                begin
                    st_next = ST_HEAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_HEAD;
            cnt_reg       <= '0;
            crc_reg       <= CRC_PRESET;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            chunk_end_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            crc_reg       <= crc_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
            chunk_end_reg <= chunk_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        len_reg      <= len_next;
        out_byte_reg <= out_byte_next;
    end

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign chunk_end = chunk_end_reg;

    a_pop_at_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (st_reg == ST_HEAD) && q_valid && adv)
        else $error("queue popped outside head state");

    a_end_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && st_reg == ST_CRC && cnt_reg == 2'd0)
            |=> chunk_end_reg && out_valid_reg && st_reg == ST_HEAD && crc_reg == CRC_PRESET)
        else $error("chunk end not flagged or CRC not preset");

    a_end_only_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && chunk_end_reg && !$past(chunk_end_reg))
            |-> $past(st_reg) == ST_CRC)
        else $error("chunk end outside CRC bytes");

endmodule

@@ rtl/png_chunk_crc_framer_unit.sv @@
// ----------------------------------------------------------------------------
// png_chunk_crc_framer_unit
// A pushed word is written into the queue; the back end then registers its
// first byte in the output register, where it is poppable. Throughput: one
// data word and one output byte per cycle while pop drains output; a begin
// word yields 8 bytes (12 for an empty chunk) and a closing data word 5.
// Reset: queue, sequencer and chunk tracking clear; CRC returns to all ones.
// ----------------------------------------------------------------------------
module png_chunk_crc_framer_unit
    import pngccf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                cmd,
    input  logic [WORD_W-1:0]   chunk_type,
    input  logic [LEN_W-1:0]    data_length,
    input  logic [BYTE_W-1:0]   data_byte,
    output logic                empty,
    input  logic                pop,
    output logic [BYTE_W-1:0]   out_byte,
    output logic                chunk_end
);

    logic     wr_valid;
    q_entry_t wr_entry;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_entry;

    assign full = q_full;

    pngccf_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .q_full      (q_full),
        .cmd         (cmd),
        .chunk_type  (chunk_type),
        .data_length (data_length),
        .data_byte   (data_byte),
        .wr_valid    (wr_valid),
        .wr_entry    (wr_entry)
    );

    pngccf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_entry (wr_entry),
        .rd_pop   (q_pop),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_entry (q_entry)
    );

    pngccf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .chunk_end (chunk_end)
    );

endmodule
